[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent assertions of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[sv/cfbl_pkg.sv]
// ----------------------------------------------------------------------------
// cfbl_pkg
// Types, codes and sizes shared by the chained free block list.
// ----------------------------------------------------------------------------
package cfbl_pkg;

   // Stack geometry.
   localparam int STACK_DEPTH = 32;
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   // Field widths of the channels.
   localparam int BLK_W    = 32;
   localparam int KIND_W   = 2;
   localparam int STAT_W   = 3;
   localparam int SIDX_W   = 6;

   // Register port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_FS_SIZE = 1'b0;

   // Input kinds.
   localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REFILL = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_GRANTED  = 3'd0;
   localparam logic [STAT_W-1:0] ST_FREED    = 3'd1;
   localparam logic [STAT_W-1:0] ST_REFILL   = 3'd2;
   localparam logic [STAT_W-1:0] ST_SPILL    = 3'd3;
   localparam logic [STAT_W-1:0] ST_NO_SPACE = 3'd4;
   localparam logic [STAT_W-1:0] ST_BAD      = 3'd5;
   localparam logic [STAT_W-1:0] ST_BUSY     = 3'd6;

   // Controller states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RETRY,
      S_SPILL
   } state_type;

   // Datapath operations.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_RETRY,
      OP_REFILL,
      OP_BUSY,
      OP_BAD,
      OP_PUSH,
      OP_ALLOC,
      OP_SPILL
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              awaiting;
      logic              can_load;
      logic              bad;
      logic              full;
      logic              refill_last;
      logic              spill_last;
   } stat_type;

endpackage

[sv/cfbl_req_if.sv]
// ----------------------------------------------------------------------------
// cfbl_req_if
// Request channel: valid/ready handshake with the request word.
// ----------------------------------------------------------------------------
interface cfbl_req_if;
   logic                             valid;
   logic                             ready;
   logic [cfbl_pkg::KIND_W-1:0]      kind;
   logic [cfbl_pkg::BLK_W-1:0]       block_number;
   logic [cfbl_pkg::BLK_W-1:0]       refill_word;

   modport source (output valid, output kind, output block_number, output refill_word,
                   input ready);
   modport sink (input valid, input kind, input block_number, input refill_word,
                 output ready);
endinterface

[sv/cfbl_rsp_if.sv]
// ----------------------------------------------------------------------------
// cfbl_rsp_if
// Response channel: valid/ready handshake with the result word.
// ----------------------------------------------------------------------------
interface cfbl_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [cfbl_pkg::STAT_W-1:0]      status;
   logic [cfbl_pkg::BLK_W-1:0]       block_id;
   logic [cfbl_pkg::BLK_W-1:0]       spill_word;
   logic [cfbl_pkg::SIDX_W-1:0]      spill_index;
   logic                             last;

   modport source (output valid, output status, output block_id, output spill_word,
                   output spill_index, output last, input ready);
   modport sink (input valid, input status, input block_id, input spill_word,
                 input spill_index, input last, output ready);
endinterface

[sv/chained_free_block_list.sv]
// ----------------------------------------------------------------------------
// chained_free_block_list
// Cached free block stack chained through storage, with a register port.
// ----------------------------------------------------------------------------
// A request word is taken in the idle state, which reads the stack top from
// the entry memory (registered read); the exec state decides and, for an
// allocate or a free, loads the response register once free. After the last
// refill word of a chain block, a retry state reads the top for the retried
// allocate. A taken free on a full stack streams 33 spill words at one per
// cycle while the response side takes them, paced by the same memory port.
// The response register lets a new request word in while a result waits.
// Entries never written read as undefined; there is no clearing pass.
module chained_free_block_list (
   input  logic                                clock,
   input  logic                                reset,
   cfbl_req_if.sink                            req,
   cfbl_rsp_if.source                          rsp,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cfbl_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cfbl_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cfbl_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   cfbl_pkg::cmd_type  cmd;
   cfbl_pkg::stat_type stat;

   logic [cfbl_pkg::CSR_DATA_W-1:0] fs_size_ff, fs_size_in;
   logic                            reg_sel;

   // Register decode on the word address.
   assign reg_sel    = csr_paddr[2] == cfbl_pkg::REG_FS_SIZE;
   assign csr_pready = 1'b1;

   always_comb begin
      fs_size_in = fs_size_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_sel) fs_size_in = csr_pwdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_size_ff <= '0;
      end else begin
         fs_size_ff <= fs_size_in;
      end
   end

   assign csr_prdata = reg_sel ? fs_size_ff : '0;

   cfbl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cfbl_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .fs_size          (fs_size_ff),
      .req_kind         (req.kind),
      .req_block_number (req.block_number),
      .req_refill_word  (req.refill_word),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .rsp_status       (rsp.status),
      .rsp_block_id     (rsp.block_id),
      .rsp_spill_word   (rsp.spill_word),
      .rsp_spill_index  (rsp.spill_index),
      .rsp_last         (rsp.last)
   );

endmodule

[sv/cfbl_ctrl.sv]
// ----------------------------------------------------------------------------
// cfbl_ctrl
// Sequencer: takes a request word, then drives the datapath through the
// decision, the optional refill retry and the spill stream.
// ----------------------------------------------------------------------------
module cfbl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cfbl_pkg::stat_type  stat,
   output cfbl_pkg::cmd_type   cmd
);

   cfbl_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfbl_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cfbl_pkg::S_IDLE: begin
            if (req_valid) state_in = cfbl_pkg::S_EXEC;
         end
         cfbl_pkg::S_EXEC: begin
            unique case (stat.kind)
               cfbl_pkg::KIND_REFILL: begin
                  if (stat.awaiting && stat.refill_last) state_in = cfbl_pkg::S_RETRY;
                  else state_in = cfbl_pkg::S_IDLE;
               end
               cfbl_pkg::KIND_UNUSED: begin
                  state_in = cfbl_pkg::S_IDLE;
               end
               cfbl_pkg::KIND_ALLOC: begin
                  if (stat.can_load) state_in = cfbl_pkg::S_IDLE;
               end
               cfbl_pkg::KIND_FREE: begin
                  if (!stat.awaiting && !stat.bad && stat.full) begin
                     state_in = cfbl_pkg::S_SPILL;
                  end else if (stat.can_load) begin
                     state_in = cfbl_pkg::S_IDLE;
                  end
               end
            endcase
         end
         cfbl_pkg::S_RETRY: begin
            state_in = cfbl_pkg::S_EXEC;
         end
         cfbl_pkg::S_SPILL: begin
            if (stat.can_load && stat.spill_last) state_in = cfbl_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = cfbl_pkg::OP_NONE;
      unique case (state_ff)
         cfbl_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = cfbl_pkg::OP_LATCH;
         end
         cfbl_pkg::S_EXEC: begin
            unique case (stat.kind)
               cfbl_pkg::KIND_REFILL: begin
                  if (stat.awaiting) cmd.op = cfbl_pkg::OP_REFILL;
               end
               cfbl_pkg::KIND_UNUSED: begin
                  cmd.op = cfbl_pkg::OP_NONE;
               end
               cfbl_pkg::KIND_ALLOC: begin
                  if (stat.can_load) begin
                     cmd.op = stat.awaiting ? cfbl_pkg::OP_BUSY : cfbl_pkg::OP_ALLOC;
                  end
               end
               cfbl_pkg::KIND_FREE: begin
                  if (stat.can_load) begin
                     priority if (stat.awaiting) cmd.op = cfbl_pkg::OP_BUSY;
                     else if (stat.bad)          cmd.op = cfbl_pkg::OP_BAD;
                     else if (!stat.full)        cmd.op = cfbl_pkg::OP_PUSH;
                     else                        cmd.op = cfbl_pkg::OP_NONE;
                  end
               end
            endcase
         end
         cfbl_pkg::S_RETRY: begin
            cmd.op = cfbl_pkg::OP_RETRY;
         end
         cfbl_pkg::S_SPILL: begin
            if (stat.can_load) cmd.op = cfbl_pkg::OP_SPILL;
         end
      endcase
   end

endmodule

[sv/cfbl_dp.sv]
// ----------------------------------------------------------------------------
// cfbl_dp
// Datapath: entry memory, stack count, refill position, spill counter,
// latched request word and the response output register.
// ----------------------------------------------------------------------------
module cfbl_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  cfbl_pkg::cmd_type                  cmd,
   output cfbl_pkg::stat_type                 stat,
   input  logic [cfbl_pkg::BLK_W-1:0]         fs_size,
   input  logic [cfbl_pkg::KIND_W-1:0]        req_kind,
   input  logic [cfbl_pkg::BLK_W-1:0]         req_block_number,
   input  logic [cfbl_pkg::BLK_W-1:0]         req_refill_word,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [cfbl_pkg::STAT_W-1:0]        rsp_status,
   output logic [cfbl_pkg::BLK_W-1:0]         rsp_block_id,
   output logic [cfbl_pkg::BLK_W-1:0]         rsp_spill_word,
   output logic [cfbl_pkg::SIDX_W-1:0]        rsp_spill_index,
   output logic                               rsp_last
);

   localparam logic [cfbl_pkg::CNT_W-1:0] DEPTH_CNT = cfbl_pkg::CNT_W'(cfbl_pkg::STACK_DEPTH);
   localparam logic [cfbl_pkg::BLK_W-1:0] DEPTH_WORD = cfbl_pkg::BLK_W'(cfbl_pkg::STACK_DEPTH);
   localparam logic [cfbl_pkg::CNT_W-1:0] ONE_CNT = cfbl_pkg::CNT_W'(1);

   // Entry memory with registered read.
   logic [cfbl_pkg::BLK_W-1:0] mem [cfbl_pkg::STACK_DEPTH];
   logic [cfbl_pkg::BLK_W-1:0] rdata_ff;
   logic                       rd_en, wr_en;
   logic [cfbl_pkg::IDX_W-1:0] rd_addr, wr_addr;
   logic [cfbl_pkg::BLK_W-1:0] wr_data;

   // Latched request word.
   logic [cfbl_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [cfbl_pkg::BLK_W-1:0]  blk_ff, blk_in;
   logic [cfbl_pkg::BLK_W-1:0]  word_ff, word_in;

   // Stack control state.
   logic [cfbl_pkg::CNT_W-1:0] count_ff, count_in;
   logic [cfbl_pkg::CNT_W-1:0] pos_ff, pos_in;
   logic [cfbl_pkg::CNT_W-1:0] sidx_ff, sidx_in;
   logic                       await_ff, await_in;

   // Output register.
   logic                        out_valid_ff, out_valid_in;
   logic [cfbl_pkg::STAT_W-1:0] out_status_ff, out_status_in;
   logic [cfbl_pkg::BLK_W-1:0]  out_id_ff, out_id_in;
   logic [cfbl_pkg::BLK_W-1:0]  out_word_ff, out_word_in;
   logic [cfbl_pkg::SIDX_W-1:0] out_index_ff, out_index_in;
   logic                        out_last_ff, out_last_in;

   logic [cfbl_pkg::CNT_W-1:0] count_m1, pos_m1;
   logic                       stack_empty;
   logic                       load;

   assign count_m1    = count_ff - ONE_CNT;
   assign pos_m1      = pos_ff - ONE_CNT;
   assign stack_empty = (count_ff == '0) || (count_ff > DEPTH_CNT);

   // Status toward the controller.
   always_comb begin
      stat.kind        = kind_ff;
      stat.awaiting    = await_ff;
      stat.can_load    = !out_valid_ff || rsp_ready;
      stat.bad         = (blk_ff == '0) || (blk_ff >= fs_size);
      stat.full        = count_ff >= DEPTH_CNT;
      stat.refill_last = pos_ff == DEPTH_CNT;
      stat.spill_last  = sidx_ff == DEPTH_CNT;
   end

   // Operation decode.
   always_comb begin
      kind_in       = kind_ff;
      blk_in        = blk_ff;
      word_in       = word_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      sidx_in       = sidx_ff;
      await_in      = await_ff;
      rd_en         = 1'b0;
      rd_addr       = count_m1[cfbl_pkg::IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = count_ff[cfbl_pkg::IDX_W-1:0];
      wr_data       = blk_ff;
      load          = 1'b0;
      out_status_in = cfbl_pkg::ST_NO_SPACE;
      out_id_in     = '0;
      out_word_in   = '0;
      out_index_in  = '0;
      out_last_in   = 1'b1;
      unique case (cmd.op)
         cfbl_pkg::OP_NONE: begin
         end
         cfbl_pkg::OP_LATCH: begin
            // Take the word and read the stack top in case it is an allocate.
            kind_in = req_kind;
            blk_in  = req_block_number;
            word_in = req_refill_word;
            rd_en   = 1'b1;
         end
         cfbl_pkg::OP_RETRY: begin
            // The last refill word turns into a pending allocate.
            kind_in = cfbl_pkg::KIND_ALLOC;
            rd_en   = 1'b1;
         end
         cfbl_pkg::OP_REFILL: begin
            if (pos_ff == '0) begin
               count_in = (word_ff > DEPTH_WORD) ? DEPTH_CNT : word_ff[cfbl_pkg::CNT_W-1:0];
            end else begin
               wr_en   = 1'b1;
               wr_addr = pos_m1[cfbl_pkg::IDX_W-1:0];
               wr_data = word_ff;
            end
            if (pos_ff == DEPTH_CNT) begin
               await_in = 1'b0;
               pos_in   = '0;
            end else begin
               pos_in = pos_ff + ONE_CNT;
            end
         end
         cfbl_pkg::OP_BUSY: begin
            load          = 1'b1;
            out_status_in = cfbl_pkg::ST_BUSY;
         end
         cfbl_pkg::OP_BAD: begin
            load          = 1'b1;
            out_status_in = cfbl_pkg::ST_BAD;
         end
         cfbl_pkg::OP_PUSH: begin
            wr_en         = 1'b1;
            count_in      = count_ff + ONE_CNT;
            load          = 1'b1;
            out_status_in = cfbl_pkg::ST_FREED;
            out_id_in     = blk_ff;
         end
         cfbl_pkg::OP_ALLOC: begin
            load = 1'b1;
            priority if (stack_empty) begin
               count_in = '0;
            end else if (rdata_ff == '0) begin
               // A zero entry marks the end of the chain; the stack is kept.
               out_status_in = cfbl_pkg::ST_NO_SPACE;
            end else if (count_ff == ONE_CNT) begin
               // Last entry names the next chain block: ask for its contents.
               count_in      = '0;
               await_in      = 1'b1;
               pos_in        = '0;
               out_status_in = cfbl_pkg::ST_REFILL;
               out_id_in     = rdata_ff;
            end else begin
               count_in      = count_m1;
               out_status_in = cfbl_pkg::ST_GRANTED;
               out_id_in     = rdata_ff;
            end
         end
         cfbl_pkg::OP_SPILL: begin
            // Word zero is the count, word k is entry k-1 read at the prior step.
            load          = 1'b1;
            out_status_in = cfbl_pkg::ST_SPILL;
            out_id_in     = blk_ff;
            out_word_in   = (sidx_ff == '0) ? DEPTH_WORD : rdata_ff;
            out_index_in  = cfbl_pkg::SIDX_W'(sidx_ff);
            out_last_in   = sidx_ff == DEPTH_CNT;
            if (sidx_ff == DEPTH_CNT) begin
               sidx_in  = '0;
               count_in = ONE_CNT;
               wr_en    = 1'b1;
               wr_addr  = '0;
            end else begin
               rd_en   = 1'b1;
               rd_addr = sidx_ff[cfbl_pkg::IDX_W-1:0];
               sidx_in = sidx_ff + ONE_CNT;
            end
         end
         default: begin
         end
      endcase
   end

   // Output register valid.
   always_comb begin
      out_valid_in = out_valid_ff;
      priority if (load)      out_valid_in = 1'b1;
      else if (rsp_ready)     out_valid_in = 1'b0;
      else                    out_valid_in = out_valid_ff;
   end

   // Entry memory.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pos_ff       <= '0;
         sidx_ff      <= '0;
         await_ff     <= 1'b0;
         kind_ff      <= cfbl_pkg::KIND_UNUSED;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         sidx_ff      <= sidx_in;
         await_ff     <= await_in;
         kind_ff      <= kind_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      blk_ff  <= blk_in;
      word_ff <= word_in;
      if (load) begin
         out_status_ff <= out_status_in;
         out_id_ff     <= out_id_in;
         out_word_ff   <= out_word_in;
         out_index_ff  <= out_index_in;
         out_last_ff   <= out_last_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_block_id    = out_id_ff;
   assign rsp_spill_word  = out_word_ff;
   assign rsp_spill_index = out_index_ff;
   assign rsp_last        = out_last_ff;

endmodule

[sv/cfbl_checker.sv]
// ----------------------------------------------------------------------------
// cfbl_checker
// Port-level checks on the response stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfbl_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [cfbl_pkg::STAT_W-1:0]        rsp_status,
   input logic [cfbl_pkg::BLK_W-1:0]         rsp_block_id,
   input logic [cfbl_pkg::BLK_W-1:0]         rsp_spill_word,
   input logic [cfbl_pkg::SIDX_W-1:0]        rsp_spill_index,
   input logic                               rsp_last
);

   // A stalled response word holds.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_block_id) && $stable(rsp_spill_word) && $stable(rsp_spill_index) && $stable(rsp_last))

   // Every result other than a spill word ends its request.
   `ASSERT_IMP(a_single_last, clock, reset, rsp_valid && rsp_status != cfbl_pkg::ST_SPILL, rsp_last && rsp_spill_word == '0 && rsp_spill_index == '0)

   // The first spill word carries the stack depth and never ends the stream.
   `ASSERT_IMP(a_spill_head, clock, reset, rsp_valid && rsp_status == cfbl_pkg::ST_SPILL && rsp_spill_index == '0, rsp_spill_word == cfbl_pkg::BLK_W'(cfbl_pkg::STACK_DEPTH) && !rsp_last)

   // Failures name no block.
   `ASSERT_IMP(a_fail_zero, clock, reset, rsp_valid && (rsp_status == cfbl_pkg::ST_BUSY || rsp_status == cfbl_pkg::ST_BAD || rsp_status == cfbl_pkg::ST_NO_SPACE), rsp_block_id == '0)

endmodule

bind chained_free_block_list cfbl_checker u_cfbl_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_status      (rsp.status),
   .rsp_block_id    (rsp.block_id),
   .rsp_spill_word  (rsp.spill_word),
   .rsp_spill_index (rsp.spill_index),
   .rsp_last        (rsp.last)
);

[sim/tb_chained_free_block_list.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chained_free_block_list
// Self-checking bench for the chained free block list. A tracker class keeps
// its own copy of the block stack and predicts every response word, and the
// bench compares the responses with it field by field. A short directed run
// covers the corner cases. Random phases at several file system sizes follow,
// with chain block loads and random handshake gaps. One phase holds off the
// response side long enough for the block to stall its request side.
// ----------------------------------------------------------------------------
module tb_chained_free_block_list;
   import cfbl_pkg::*;

   localparam int CLOCK_HALF     = 4;
   localparam int RESET_CYCLES   = 12;
   localparam int SETTLE_CYCLES  = 8;
   localparam int END_CYCLES     = 20;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 6;
   localparam int PHASE_ITEMS    = 55;
   localparam logic [CSR_ADDR_W-1:0] FS_SIZE_ADDR = CSR_ADDR_W'(4 * REG_FS_SIZE);

   // One response word as the block delivers it.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [BLK_W-1:0]  block_id;
      logic [BLK_W-1:0]  spill_word;
      logic [SIDX_W-1:0] spill_index;
      logic              last;
   } block_result;

   // Tracks the free block stack and the responses that are still owed.
   class free_list_tracker;
      logic [BLK_W-1:0]  stack_mem [STACK_DEPTH];
      logic [CNT_W-1:0]  depth_used;
      bit                loading;
      logic [SIDX_W-1:0] load_pos;
      logic [BLK_W-1:0]  fs_limit;
      block_result       owed [$];
      int unsigned       failures;
      int unsigned       results_seen;
      int unsigned       spills;
      int unsigned       loads;

      function new();
         depth_used   = '0;
         loading      = 1'b0;
         load_pos     = '0;
         fs_limit     = '0;
         failures     = 0;
         results_seen = 0;
         spills       = 0;
         loads        = 0;
      endfunction

      function void owe(logic [STAT_W-1:0] st, logic [BLK_W-1:0] id,
                        logic [BLK_W-1:0] word, logic [SIDX_W-1:0] idx, logic fin);
         block_result r;
         r.status      = st;
         r.block_id    = id;
         r.spill_word  = word;
         r.spill_index = idx;
         r.last        = fin;
         owed.push_back(r);
      endfunction

      // Allocate: pop the top entry; an empty pop of a chain entry starts a load.
      function void pop_top();
         logic [BLK_W-1:0] top;
         if (depth_used == 0 || depth_used > STACK_DEPTH) begin
            depth_used = '0;
            owe(ST_NO_SPACE, '0, '0, '0, 1'b1);
            return;
         end
         depth_used = depth_used - 1'b1;
         top = stack_mem[depth_used];
         if (top == 0) begin
            depth_used = depth_used + 1'b1;
            owe(ST_NO_SPACE, '0, '0, '0, 1'b1);
         end else if (depth_used == 0) begin
            loading  = 1'b1;
            load_pos = '0;
            loads++;
            owe(ST_REFILL, top, '0, '0, 1'b1);
         end else begin
            owe(ST_GRANTED, top, '0, '0, 1'b1);
         end
      endfunction

      // Free: push, or spill the whole stack into the freed block when full.
      function void push_block(logic [BLK_W-1:0] blk);
         if (blk == 0 || blk >= fs_limit) begin
            owe(ST_BAD, '0, '0, '0, 1'b1);
         end else if (depth_used >= STACK_DEPTH) begin
            owe(ST_SPILL, blk, BLK_W'(STACK_DEPTH), '0, 1'b0);
            for (int k = 0; k < STACK_DEPTH; k++)
               owe(ST_SPILL, blk, stack_mem[k], SIDX_W'(k + 1), k == STACK_DEPTH - 1);
            depth_used   = CNT_W'(1);
            stack_mem[0] = blk;
            spills++;
         end else begin
            stack_mem[depth_used] = blk;
            depth_used = depth_used + 1'b1;
            owe(ST_FREED, blk, '0, '0, 1'b1);
         end
      endfunction

      // Chain block word: the count first, then the entries; the last retries.
      function void take_refill(logic [BLK_W-1:0] w);
         if (load_pos == 0)
            depth_used = (w > STACK_DEPTH) ? CNT_W'(STACK_DEPTH) : w[CNT_W-1:0];
         else if (load_pos <= STACK_DEPTH)
            stack_mem[load_pos - 1] = w;
         if (load_pos >= STACK_DEPTH) begin
            loading  = 1'b0;
            load_pos = '0;
            pop_top();
         end else begin
            load_pos = load_pos + 1'b1;
         end
      endfunction

      // Notes one accepted request word; returns 1 when the block ignores it.
      function bit note_request(logic [KIND_W-1:0] kind, logic [BLK_W-1:0] blk,
                                logic [BLK_W-1:0] w);
         if (kind == KIND_REFILL) begin
            if (!loading)
               return 1'b1;
            take_refill(w);
            return 1'b0;
         end
         if (kind == KIND_UNUSED)
            return 1'b1;
         if (loading)
            owe(ST_BUSY, '0, '0, '0, 1'b1);
         else if (kind == KIND_ALLOC)
            pop_top();
         else
            push_block(blk);
         return 1'b0;
      endfunction

      function void compare_field(string name, logic [BLK_W-1:0] want, logic [BLK_W-1:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
         end
      endfunction

      // Compares one accepted response word with the oldest one owed.
      function void check_response(block_result got);
         block_result want;
         results_seen++;
         if (owed.size() == 0) begin
            $error("response word with none owed: status %0d block 0x%0h",
                   got.status, got.block_id);
            failures++;
            return;
         end
         want = owed.pop_front();
         compare_field("status", BLK_W'(want.status), BLK_W'(got.status));
         compare_field("block_id", want.block_id, got.block_id);
         compare_field("spill_word", want.spill_word, got.spill_word);
         compare_field("spill_index", BLK_W'(want.spill_index), BLK_W'(got.spill_index));
         compare_field("last", BLK_W'(want.last), BLK_W'(got.last));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cfbl_req_if req_ch ();
   cfbl_rsp_if rsp_ch ();

   free_list_tracker tracker;
   bit               reset_done;
   bit               calm;
   bit               hold_rsp;
   int unsigned      words_sent;
   int unsigned      effective_words;
   int unsigned      fs_settings;
   int unsigned      stall_cycles;

   chained_free_block_list dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Handshake gap for either side; calm stretches run without gaps.
   function automatic int unsigned pick_gap();
      return calm ? 0 : $urandom_range(0, 4);
   endfunction

   // Block number for a free: mostly in range, sometimes zero or past the end.
   function automatic logic [BLK_W-1:0] pick_free_block();
      int unsigned      r;
      logic [BLK_W-1:0] lim;
      lim = tracker.fs_limit;
      r   = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      if (r == 1)
         return lim;
      if (r == 2 || lim < 2)
         return $urandom;
      return $urandom_range(lim - 1, 1);
   endfunction

   // Content of a chain block word at a given position.
   function automatic logic [BLK_W-1:0] chain_word(logic [SIDX_W-1:0] pos);
      int unsigned r;
      r = $urandom_range(0, 15);
      if (pos == 0) begin
         if (r < 2)
            return '0;
         if (r < 4)
            return $urandom_range(32'hFFFF_FFFF, STACK_DEPTH + 1);
         return $urandom_range(STACK_DEPTH, 1);
      end
      // The bottom entry links the next chain block; zero ends the list.
      if (pos == 1)
         return (r < 4) ? '0 : $urandom;
      return (r == 0) ? '0 : $urandom;
   endfunction

   // Offers one request word and waits until the block takes it.
   task automatic send_word(logic [KIND_W-1:0] kind, logic [BLK_W-1:0] blk,
                            logic [BLK_W-1:0] word);
      int unsigned gap;
      gap = pick_gap();
      if ($urandom_range(0, 29) == 0)
         calm = !calm;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.kind         <= kind;
      req_ch.block_number <= blk;
      req_ch.refill_word  <= word;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
      if (!tracker.note_request(kind, blk, word))
         effective_words++;
      @(negedge clock);
   endtask

   // One random request word, shaped by whether a chain block is loading.
   task automatic random_word(int unsigned alloc_pct);
      logic [KIND_W-1:0] kind;
      logic [BLK_W-1:0]  blk;
      logic [BLK_W-1:0]  word;
      int unsigned       r;
      r    = $urandom_range(0, 99);
      blk  = $urandom;
      word = $urandom;
      if (tracker.loading) begin
         if (r < 90) begin
            kind = KIND_REFILL;
            word = chain_word(tracker.load_pos);
         end else if (r < 94) begin
            kind = KIND_ALLOC;
         end else if (r < 97) begin
            kind = KIND_FREE;
         end else begin
            kind = KIND_UNUSED;
         end
      end else if (r < 5) begin
         kind = KIND_REFILL;
      end else if (r < 8) begin
         kind = KIND_UNUSED;
      end else if (r < 8 + alloc_pct * 92 / 100) begin
         kind = KIND_ALLOC;
      end else begin
         kind = KIND_FREE;
         blk  = pick_free_block();
      end
      send_word(kind, blk, word);
   endtask

   // Waits until every owed response word has arrived, then lets the block settle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (tracker.owed.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One register access: setup cycle, then access cycle until pready.
   task automatic csr_access(bit wr, logic [CSR_ADDR_W-1:0] addr,
                             logic [CSR_DATA_W-1:0] data, output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Writes the file system size and reads it back.
   task automatic write_fs_size(logic [BLK_W-1:0] size);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, FS_SIZE_ADDR, size, rd);
      tracker.fs_limit = size;
      fs_settings++;
      csr_access(1'b0, FS_SIZE_ADDR, '0, rd);
      if (rd !== size) begin
         $error("fs_size mismatch: expected 0x%0h, got 0x%0h", size, rd);
         tracker.failures++;
      end
   endtask

   // Response side: random gaps, plus one long hold-off when asked.
   initial begin
      int unsigned gap;
      wait (reset_done);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         tracker.check_response({rsp_ch.status, rsp_ch.block_id, rsp_ch.spill_word,
                                 rsp_ch.spill_index, rsp_ch.last});
         @(negedge clock);
      end
   end

   // Watchdog: ends the run when no word moves for too long.
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                   (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no word moved for %0d cycles", stall_cycles);
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Main sequence: reset, directed corner cases, then random phases.
   initial begin
      logic [CSR_DATA_W-1:0] rd;
      logic [BLK_W-1:0]      phase_fs [PHASES];
      int unsigned           phase_alloc [PHASES];
      int unsigned           start_words;
      bit                    pressure_done;

      clock               = 1'b0;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.kind         = KIND_ALLOC;
      req_ch.block_number = '0;
      req_ch.refill_word  = '0;
      rsp_ch.ready        = 1'b0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      reset_done          = 1'b0;
      calm                = 1'b0;
      hold_rsp            = 1'b0;
      pressure_done       = 1'b0;
      words_sent          = 0;
      effective_words     = 0;
      fs_settings         = 0;
      tracker             = new();

      phase_fs    = '{32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1, 32'd100, 32'h8000_0000};
      phase_alloc = '{25, 50, 40, 60, 30, 55};
      phase_fs[2] = $urandom_range(32'hFFFF_FFFF, 2);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset      <= 1'b0;
      reset_done  = 1'b1;
      @(negedge clock);

      // The size resets to zero, so every free is rejected at first.
      csr_access(1'b0, FS_SIZE_ADDR, '0, rd);
      if (rd !== '0) begin
         $error("fs_size mismatch: expected 0x0, got 0x%0h", rd);
         tracker.failures++;
      end
      send_word(KIND_FREE, 32'd1, '0);
      drain();
      write_fs_size(32'd100);

      // Empty stack, rejected frees and ignored words.
      send_word(KIND_ALLOC, '0, '0);
      send_word(KIND_FREE, 32'd0, '0);
      send_word(KIND_FREE, 32'd100, '0);
      send_word(KIND_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(KIND_REFILL, '0, 32'h5A5A_A5A5);
      send_word(KIND_UNUSED, 32'hFFFF_FFFF, '0);

      // A single entry becomes a chain block; allocates and frees during the load are busy.
      send_word(KIND_FREE, 32'd99, '0);
      send_word(KIND_ALLOC, '0, '0);
      send_word(KIND_ALLOC, '0, '0);
      send_word(KIND_FREE, 32'd7, '0);
      send_word(KIND_UNUSED, '0, '0);

      // Chain block with an oversized count and a zero top entry.
      send_word(KIND_REFILL, '0, 32'd40);
      for (int k = 0; k < STACK_DEPTH; k++) begin
         if (k == 0)
            send_word(KIND_REFILL, '0, 32'hFFFF_FFFF);
         else if (k == STACK_DEPTH - 1)
            send_word(KIND_REFILL, '0, 32'd0);
         else if (k == 1)
            send_word(KIND_REFILL, '0, 32'h8000_0000);
         else
            send_word(KIND_REFILL, '0, 32'(k * 3 + 1));
      end

      // Full stack spills into the freed block, then push, grant and chain again.
      send_word(KIND_FREE, 32'd60, '0);
      send_word(KIND_FREE, 32'd61, '0);
      send_word(KIND_ALLOC, '0, '0);
      send_word(KIND_ALLOC, '0, '0);
      drain();

      // Random phases at different file system sizes.
      for (int p = 0; p < PHASES; p++) begin
         write_fs_size(phase_fs[p]);
         start_words = effective_words;
         while (effective_words - start_words < PHASE_ITEMS) begin
            if (p == 0 && !pressure_done && effective_words - start_words >= 20) begin
               hold_rsp      = 1'b1;
               pressure_done = 1'b1;
            end
            random_word(phase_alloc[p]);
         end
         drain();
      end

      repeat (END_CYCLES) @(negedge clock);
      if (tracker.owed.size() != 0) begin
         $error("%0d response words never arrived", tracker.owed.size());
         tracker.failures++;
      end

      $display("Run covered %0d request words and %0d checked responses at %0d sizes.",
               words_sent, tracker.results_seen, fs_settings);
      $display("It included %0d chain block loads and %0d full-stack spills.",
               tracker.loads, tracker.spills);
      if (tracker.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/cfbl_pkg.sv
sv/cfbl_req_if.sv
sv/cfbl_rsp_if.sv
sv/cfbl_ctrl.sv
sv/cfbl_dp.sv
sv/chained_free_block_list.sv
sv/cfbl_checker.sv
sim/tb_chained_free_block_list.sv
